// ===== hdl/dfgw_pkg.sv =====
// Shared types, codes and microcode ROM of the depth-first graph walk unit.
// Depends on nothing; every other file in this folder uses it.
`default_nettype none

package dfgw_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_DEGREE_DEF   = 8;

    // Fixed field widths of the command and result items
    localparam int FUNC_W   = 2;
    localparam int VTX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int NUMV_W   = 5;

    localparam logic [NUMV_W-1:0] NUMV_RESET = 5'd16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WALK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_VISITED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VTX_W-1:0]  from_vertex;
        logic [VTX_W-1:0]  to_vertex;
        logic [VTX_W-1:0]  start_vertex;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VTX_W-1:0]    node;
        logic [VTX_W-1:0]    reached_from;
        logic                is_root;
        logic                last;
    } out_item_t;

    // Datapath actions, one per microcode step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ADD,
        ACT_CLEAR,
        ACT_WINIT,
        ACT_LOAD,
        ACT_CHECK,
        ACT_VISIT,
        ACT_FINISH
    } act_t;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START_BAD,
        COND_STACK_EMPTY,
        COND_SLOT_DONE
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_IDLE   = 3'd0;
    localparam upc_t UPC_ADD    = 3'd1;
    localparam upc_t UPC_CLEAR  = 3'd2;
    localparam upc_t UPC_WINIT  = 3'd3;
    localparam upc_t UPC_LOAD   = 3'd4;
    localparam upc_t UPC_CHECK  = 3'd5;
    localparam upc_t UPC_VISIT  = 3'd6;
    localparam upc_t UPC_FINISH = 3'd7;

    // One control word: dispatch on a new item, or act then jump on cond
    typedef struct packed {
        logic  dispatch;
        act_t  act;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    typedef struct packed {
        logic load_cmd;
        act_t act;
    } ctrl_t;

    typedef struct packed {
        logic start_bad;
        logic stack_empty;
        logic slot_done;
    } flags_t;

    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t w;
        case (upc)
            UPC_IDLE:   w = '{1'b1, ACT_NONE,   COND_ALWAYS,      UPC_IDLE};
            UPC_ADD:    w = '{1'b0, ACT_ADD,    COND_ALWAYS,      UPC_IDLE};
            UPC_CLEAR:  w = '{1'b0, ACT_CLEAR,  COND_ALWAYS,      UPC_IDLE};
            UPC_WINIT:  w = '{1'b0, ACT_WINIT,  COND_START_BAD,   UPC_IDLE};
            UPC_LOAD:   w = '{1'b0, ACT_LOAD,   COND_STACK_EMPTY, UPC_FINISH};
            UPC_CHECK:  w = '{1'b0, ACT_CHECK,  COND_SLOT_DONE,   UPC_LOAD};
            UPC_VISIT:  w = '{1'b0, ACT_VISIT,  COND_ALWAYS,      UPC_LOAD};
            UPC_FINISH: w = '{1'b0, ACT_FINISH, COND_ALWAYS,      UPC_IDLE};
            default:    w = '{1'b1, ACT_NONE,   COND_ALWAYS,      UPC_IDLE};
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_entry(input logic [FUNC_W-1:0] func);
        upc_t e;
        case (func)
            FUNC_ADD:   e = UPC_ADD;
            FUNC_WALK:  e = UPC_WINIT;
            FUNC_CLEAR: e = UPC_CLEAR;
            default:    e = UPC_IDLE;
        endcase
        return e;
    endfunction

    function automatic out_item_t status_item(input logic [STATUS_W-1:0] st);
        out_item_t r;
        r              = '0;
        r.status       = st;
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/depth_first_graph_walk_unit.sv =====
// Top level of the depth-first graph walk unit: APB register and block wiring.
// Depends on dfgw_pkg, dfgw_useq and dfgw_datapath.
`default_nettype none

// Usage
//   Command channel: drive command and raise start; the item is taken at the
//   clock edge where start is high and busy is low. Hold off while busy.
//   Result channel: each result item shows on result for one cycle with done
//   high. The receiver must take it then; there is no backpressure.
//   Register: num_vertices at byte address 0 over the APB port, which the user
//   must write only while busy is low and no result is still due (not enforced).
// Sequence
//   Add edge and clear: one result, registered from the ADD or CLEAR step.
//   Walk: each stack step runs LOAD, CHECK and, for an edge, VISIT in the
//   microcode, with one read of the neighbour memory per edge.
//   A visit result is held back until the next visit or the end of the walk so
//   that the last flag is known.
//   A new item can be taken as soon as busy is low.
// Reset
//   rst_n clears the step counter, degree counts, visit marks, stack depth and
//   the result strobe, and sets num_vertices to 16. The neighbour memory and
//   stack entries are not cleared; only written entries are ever read.

module depth_first_graph_walk_unit
#(
    parameter int MAX_VERTICES = dfgw_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = dfgw_pkg::MAX_DEGREE_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire dfgw_pkg::in_item_t   command,
    // Result channel
    output logic                      done,
    output dfgw_pkg::out_item_t       result,
    // Register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [dfgw_pkg::NUMV_W-1:0] num_vertices_reg;
    logic [dfgw_pkg::NUMV_W-1:0] num_vertices_next;
    logic                        reg_write;
    dfgw_pkg::ctrl_t             ctrl;
    dfgw_pkg::flags_t            flags;

    // Register 0 sits at byte address 0; address bit 2 picks the register
    assign pready    = 1'b1;
    assign reg_write = psel & penable & pwrite & pready & ~paddr[2];

    always_comb
    begin
        num_vertices_next = reg_write ? pwdata[dfgw_pkg::NUMV_W-1:0] : num_vertices_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= dfgw_pkg::NUMV_RESET;
        end
        else
        begin
            num_vertices_reg <= num_vertices_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata[dfgw_pkg::NUMV_W-1:0] = num_vertices_reg;
        end
    end

    // Step counter and control ROM
    dfgw_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (command.func),
        .flags (flags),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Storage and result register
    dfgw_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (command),
        .num_vertices (num_vertices_reg),
        .flags        (flags),
        .done         (done),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hdl/dfgw_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on dfgw_pkg.
`default_nettype none

module dfgw_useq
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dfgw_pkg::FUNC_W-1:0]  func,
    input  wire dfgw_pkg::flags_t             flags,
    output logic                              busy,
    output dfgw_pkg::ctrl_t                   ctrl
);

    dfgw_pkg::upc_t   upc_reg;
    dfgw_pkg::upc_t   upc_next;
    dfgw_pkg::ucode_t uword;
    logic             cond_hit;

    assign uword = dfgw_pkg::ucode_rom(upc_reg);

    // Next step
    always_comb
    begin
        case (uword.cond)
            dfgw_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            dfgw_pkg::COND_START_BAD:   cond_hit = flags.start_bad;
            dfgw_pkg::COND_STACK_EMPTY: cond_hit = flags.stack_empty;
            dfgw_pkg::COND_SLOT_DONE:   cond_hit = flags.slot_done;
            default:                    cond_hit = 1'b1;
        endcase

        if (uword.dispatch)
        begin
            upc_next = start ? dfgw_pkg::dispatch_entry(func) : upc_reg;
        end
        else if (cond_hit)
        begin
            upc_next = uword.target;
        end
        else
        begin
            upc_next = dfgw_pkg::upc_t'(upc_reg + 3'd1);
        end
    end

    // Control outputs
    always_comb
    begin
        busy          = ~uword.dispatch;
        ctrl.load_cmd = uword.dispatch & start;
        ctrl.act      = uword.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= dfgw_pkg::UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dfgw_datapath.sv =====
// Datapath: adjacency memory, degree counts, visit marks, walk stack, result register.
// Depends on dfgw_pkg; driven by the control word from dfgw_useq.
`default_nettype none

module dfgw_datapath
#(
    parameter int MAX_VERTICES = dfgw_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = dfgw_pkg::MAX_DEGREE_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dfgw_pkg::ctrl_t              ctrl,
    input  wire dfgw_pkg::in_item_t           command,
    input  wire logic [dfgw_pkg::NUMV_W-1:0]  num_vertices,
    output dfgw_pkg::flags_t                  flags,
    output logic                              done,
    output dfgw_pkg::out_item_t               result
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int SDW       = $clog2(MAX_VERTICES + 1);
    localparam int DW        = $clog2(MAX_DEGREE + 1);
    localparam int MEM_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = (SDW > dfgw_pkg::NUMV_W) ? SDW : dfgw_pkg::NUMV_W;

    localparam int XW = dfgw_pkg::VTX_W;

    // Effective vertex count, clamped to 1..MAX_VERTICES
    logic [CW-1:0] nv_raw;
    logic [CW-1:0] nv_c;

    dfgw_pkg::in_item_t  cmd_reg,        cmd_next;
    logic [SDW-1:0]      depth_reg,      depth_next;
    logic [XW-1:0]       v_reg;
    logic [DW-1:0]       s_reg;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [DW-1:0]       degree_reg [MAX_VERTICES];
    logic [DW-1:0]       degree_next [MAX_VERTICES];
    dfgw_pkg::out_item_t pend_reg,       pend_next;
    logic                pend_valid_reg, pend_valid_next;
    dfgw_pkg::out_item_t res_reg,        res_next;
    logic                res_valid_reg,  res_valid_next;

    // Walk stack, written at one place a cycle
    logic [XW-1:0]       stk_vtx_mem  [MAX_VERTICES];
    logic [DW-1:0]       stk_slot_mem [MAX_VERTICES];
    logic                stk_vtx_we;
    logic                stk_slot_we;
    logic                stk_re;
    logic [VW-1:0]       stk_waddr;
    logic [XW-1:0]       stk_wvtx;
    logic [DW-1:0]       stk_wslot;

    // Neighbour store
    logic [XW-1:0]       nbr_mem [MEM_DEPTH];
    logic                nbr_we;
    logic [AW-1:0]       nbr_waddr;
    logic [XW-1:0]       nbr_wdata;
    logic                nbr_re;
    logic [AW-1:0]       nbr_raddr;
    logic [XW-1:0]       nbr_rdata_reg;

    logic [VW-1:0]       from_i;
    logic [VW-1:0]       start_i;
    logic [VW-1:0]       v_i;
    logic [VW-1:0]       w_i;
    logic [VW-1:0]       top_i;
    logic [DW-1:0]       deg_from;
    logic [DW-1:0]       deg_v;
    logic                edge_bad;
    logic                list_full;
    logic                start_bad;
    logic                slot_done;
    logic                w_take;

    always_comb
    begin
        nv_raw = CW'(num_vertices);
        if (nv_raw == '0)
        begin
            nv_c = CW'(1);
        end
        else if (nv_raw > CW'(MAX_VERTICES))
        begin
            nv_c = CW'(MAX_VERTICES);
        end
        else
        begin
            nv_c = nv_raw;
        end
    end

    always_comb
    begin
        from_i    = VW'(cmd_reg.from_vertex);
        start_i   = VW'(cmd_reg.start_vertex);
        v_i       = VW'(v_reg);
        w_i       = VW'(nbr_rdata_reg);
        top_i     = VW'(depth_reg - SDW'(1));
        deg_from  = degree_reg[from_i];
        deg_v     = degree_reg[v_i];
        edge_bad  = (CW'(cmd_reg.from_vertex) >= nv_c) || (CW'(cmd_reg.to_vertex) >= nv_c);
        list_full = deg_from >= DW'(MAX_DEGREE);
        start_bad = CW'(cmd_reg.start_vertex) >= nv_c;
        slot_done = s_reg >= deg_v;
        w_take    = (CW'(nbr_rdata_reg) < nv_c) && !visited_reg[w_i]
                    && (depth_reg < SDW'(MAX_VERTICES));
    end

    assign flags.start_bad   = start_bad;
    assign flags.stack_empty = (depth_reg == '0);
    assign flags.slot_done   = slot_done;

    always_comb
    begin
        cmd_next        = ctrl.load_cmd ? command : cmd_reg;
        depth_next      = depth_reg;
        visited_next    = visited_reg;
        degree_next     = degree_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;
        stk_vtx_we      = 1'b0;
        stk_slot_we     = 1'b0;
        stk_re          = 1'b0;
        stk_waddr       = '0;
        stk_wvtx        = '0;
        stk_wslot       = '0;
        nbr_we          = 1'b0;
        nbr_waddr       = '0;
        nbr_wdata       = cmd_reg.to_vertex;
        nbr_re          = 1'b0;
        nbr_raddr       = '0;

        case (ctrl.act)
            dfgw_pkg::ACT_ADD:
            begin
                res_valid_next = 1'b1;
                if (edge_bad)
                begin
                    res_next = dfgw_pkg::status_item(dfgw_pkg::ST_RANGE);
                end
                else if (list_full)
                begin
                    res_next = dfgw_pkg::status_item(dfgw_pkg::ST_FULL);
                end
                else
                begin
                    nbr_we              = 1'b1;
                    nbr_waddr           = AW'(AW'(from_i) * AW'(MAX_DEGREE)) + AW'(deg_from);
                    degree_next[from_i] = DW'(deg_from + DW'(1));
                    res_next            = dfgw_pkg::status_item(dfgw_pkg::ST_STORED);
                end
            end

            dfgw_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    degree_next[i] = '0;
                end
                res_valid_next = 1'b1;
                res_next       = dfgw_pkg::status_item(dfgw_pkg::ST_CLEARED);
            end

            dfgw_pkg::ACT_WINIT:
            begin
                if (start_bad)
                begin
                    res_valid_next = 1'b1;
                    res_next       = dfgw_pkg::status_item(dfgw_pkg::ST_RANGE);
                end
                else
                begin
                    visited_next          = '0;
                    visited_next[start_i] = 1'b1;
                    stk_vtx_we            = 1'b1;
                    stk_slot_we           = 1'b1;
                    stk_waddr             = '0;
                    stk_wvtx              = cmd_reg.start_vertex;
                    stk_wslot             = '0;
                    depth_next            = SDW'(1);
                    pend_valid_next       = 1'b1;
                    pend_next.status       = dfgw_pkg::ST_VISITED;
                    pend_next.node         = cmd_reg.start_vertex;
                    pend_next.reached_from = cmd_reg.start_vertex;
                    pend_next.is_root      = 1'b1;
                    pend_next.last         = 1'b0;
                end
            end

            dfgw_pkg::ACT_LOAD:
            begin
                stk_re = (depth_reg != '0);
            end

            dfgw_pkg::ACT_CHECK:
            begin
                if (slot_done)
                begin
                    depth_next = depth_reg - SDW'(1);
                end
                else
                begin
                    nbr_re      = 1'b1;
                    nbr_raddr   = AW'(AW'(v_i) * AW'(MAX_DEGREE)) + AW'(s_reg);
                    stk_slot_we = 1'b1;
                    stk_waddr   = top_i;
                    stk_wslot   = DW'(s_reg + DW'(1));
                end
            end

            dfgw_pkg::ACT_VISIT:
            begin
                if (w_take)
                begin
                    visited_next[w_i] = 1'b1;
                    stk_vtx_we        = 1'b1;
                    stk_slot_we       = 1'b1;
                    stk_waddr         = VW'(depth_reg);
                    stk_wvtx          = nbr_rdata_reg;
                    stk_wslot         = '0;
                    depth_next        = depth_reg + SDW'(1);
                    // Release the held visit now that another follows it
                    res_valid_next    = pend_valid_reg;
                    res_next          = pend_reg;
                    pend_valid_next   = 1'b1;
                    pend_next.status       = dfgw_pkg::ST_VISITED;
                    pend_next.node         = nbr_rdata_reg;
                    pend_next.reached_from = v_reg;
                    pend_next.is_root      = 1'b0;
                    pend_next.last         = 1'b0;
                end
            end

            dfgw_pkg::ACT_FINISH:
            begin
                res_valid_next  = pend_valid_reg;
                res_next        = pend_reg;
                res_next.last   = 1'b1;
                pend_valid_next = 1'b0;
            end

            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                degree_reg[i] <= '0;
            end
        end
        else
        begin
            depth_reg      <= depth_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            degree_reg     <= degree_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    // Stack top is read into the vertex and slot registers
    always_ff @(posedge clk)
    begin
        if (stk_vtx_we)
        begin
            stk_vtx_mem[stk_waddr] <= stk_wvtx;
        end
        if (stk_slot_we)
        begin
            stk_slot_mem[stk_waddr] <= stk_wslot;
        end
        if (stk_re)
        begin
            v_reg <= stk_vtx_mem[top_i];
            s_reg <= stk_slot_mem[top_i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        if (nbr_re)
        begin
            nbr_rdata_reg <= nbr_mem[nbr_raddr];
        end
    end

    assign done   = res_valid_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== hdl/dfgw_checker.sv =====
// Port-level checks on the depth-first graph walk unit, bound to its top level.
// Depends on dfgw_pkg and depth_first_graph_walk_unit.
`default_nettype none

module dfgw_checker
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire dfgw_pkg::in_item_t  command,
    input  wire logic                done,
    input  wire dfgw_pkg::out_item_t result
);

    // A real operation keeps the block busy in the following cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command.func == dfgw_pkg::FUNC_ADD
            || command.func == dfgw_pkg::FUNC_WALK
            || command.func == dfgw_pkg::FUNC_CLEAR)) |=> busy)
        else $error("block not busy after taking an operation");

    // The last item of a command is never followed at once by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |=> !done)
        else $error("result straight after a last result");

    // Only walk visits come in runs; every other result closes its command
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != dfgw_pkg::ST_VISITED) |-> result.last)
        else $error("non-visit result without last");

    // More items are still due, so the walk must still be running
    a_busy_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> busy)
        else $error("walk result pending while idle");

    a_root_self: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_root) |-> (result.node == result.reached_from))
        else $error("root result not reached from itself");

endmodule

bind depth_first_graph_walk_unit dfgw_checker u_dfgw_checker (.*);

`default_nettype wire
